// ----- rtl/fsf_pkg.sv -----
// fsf_pkg: shared constants and types of the four-step FFT unit.
// Used by fsf_twiddle and four_step_fft_unit; depends on nothing.
package fsf_pkg;

    // default sizing of the unit
    localparam int MAX_POINTS_DEF   = 4096;
    localparam int TWIDDLE_BITS_DEF = 18;

    // fixed field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int WORK_BITS    = 28;
    localparam int INDEX_BITS   = 12;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 72;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    // size register range and reset
    localparam int         MIN_LOG2        = 6;
    localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

    // register index (paddr[2])
    localparam logic REG_SIZE_LOG2 = 1'b0;
    localparam logic REG_INVERSE   = 1'b1;

    // input word kind
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    // pi/2 in Q60
    localparam longint unsigned HALF_PI_Q60 = 64'h1921FB54442D1846;

    // result status
    typedef enum logic [1:0] {
        STAT_BIN    = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_REJECT = 2'd2
    } t_status;

endpackage

// ----- rtl/fsf_twiddle.sv -----
// fsf_twiddle: twiddle ROM, W_MAX^j = c + i*d, registered read.
// Quarter-wave cosine table built at elaboration; uses fsf_pkg.
module fsf_twiddle #(
    parameter int MAX_POINTS   = fsf_pkg::MAX_POINTS_DEF,
    parameter int TWIDDLE_BITS = fsf_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_j,
    output logic signed [TWIDDLE_BITS-1:0]      o_c,
    output logic signed [TWIDDLE_BITS-1:0]      o_d
);

    localparam int LOG_MAX = $clog2(MAX_POINTS);
    localparam int QUARTER = MAX_POINTS / 4;
    localparam int RA_W    = LOG_MAX - 1;
    localparam int R_W     = LOG_MAX - 2;
    localparam int TW_FRAC = TWIDDLE_BITS - 1;
    localparam longint unsigned TH_STEP = fsf_pkg::HALF_PI_Q60 / 64'(QUARTER);
    localparam longint unsigned TAYLOR_DIV [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    typedef logic [TW_FRAC-1:0] t_rom [0:QUARTER];

    // Q30 Taylor series of cos, rounded half up to TW_FRAC bits
    function automatic logic [TW_FRAC-1:0] f_cos(input longint unsigned r);
        longint unsigned th60, th, x2, term, q, lim;
        longint          sum;
        int              n;
        th60 = TH_STEP * r;
        th   = (th60 + (64'd1 << 29)) >> 30;
        x2   = (th * th) >> 30;
        term = 64'd1 << 30;
        sum  = 64'sd1 <<< 30;
        for (n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (64'sd1 <<< 30)) begin
            sum = 64'sd1 <<< 30;
        end
        q   = (longint'(sum) + (64'd1 << (29 - TW_FRAC))) >> (30 - TW_FRAC);
        lim = (64'd1 << TW_FRAC) - 64'd1;
        if (q > lim) begin
            q = lim;
        end
        return TW_FRAC'(q);
    endfunction

    function automatic t_rom f_build();
        t_rom        rom;
        int unsigned r;
        for (r = 0; r <= QUARTER; r++) begin
            rom[r] = f_cos(64'(r));
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = f_build();

    logic [RA_W-1:0]    addr_cos, addr_sin;
    logic [TW_FRAC-1:0] r_cv, r_sv;
    logic [1:0]         r_q;
    logic signed [TWIDDLE_BITS-1:0] cv, sv, co, si;

    assign addr_cos = RA_W'(i_j[R_W-1:0]);
    assign addr_sin = RA_W'(QUARTER) - RA_W'(i_j[R_W-1:0]);

    // two registered ROM reads: cos(r) and cos(quarter - r)
    always_ff @(posedge i_clk) begin
        r_cv <= COS_ROM[addr_cos];
        r_sv <= COS_ROM[addr_sin];
        r_q  <= i_j[LOG_MAX-1 -: 2];
    end

    // quadrant fold
    always_comb begin
        cv = $signed({1'b0, r_cv});
        sv = $signed({1'b0, r_sv});
        case (r_q)
            2'd0: begin
                co = cv;
                si = sv;
            end
            2'd1: begin
                co = -sv;
                si = cv;
            end
            2'd2: begin
                co = -cv;
                si = -sv;
            end
            default: begin
                co = sv;
                si = -cv;
            end
        endcase
    end

    assign o_c = co;
    assign o_d = -si;

endmodule

// ----- rtl/four_step_fft_unit.sv -----
// four_step_fft_unit: top level of the four-step FFT (load, transform, readout).
// Depends on fsf_pkg and fsf_twiddle.
//
// Usage. Words enter on the s_axis channel: tuser[0] = 0 pushes a sample
// (tdata = imag:real, Q1.15), tuser[0] = 1 pulls the next bin. After N pushes
// the unit computes the DFT of N = 2^size_log2 points in place and then hands
// bins out in natural order, one per pull, on m_axis (tdata = index:imag:real,
// tlast on bin N-1, tuser = status). A pull with nothing ready answers status
// empty; a push while bins are pending answers status reject. Pushes answer
// nothing.
// Pushes can follow one another back to back; a pull passes through a
// memory-read state (S_FETCH) before the next word is taken. The transform
// runs on one complex multiply-accumulate unit fed by one memory read per
// cycle, N = N1*N2, N1 = 2^ceil(m/2), N2 = 2^floor(m/2); s_axis tready is low meanwhile.
// A word is taken only when the output register is free or being emptied,
// so a stalled receiver holds the result and, in turn, the input.
// Reset (synchronous, active low) empties the unit; size_log2 = 10, forward.
// A register write over APB aborts a transform and empties the unit.
// No clearing pass: the sample stores are written before they are read.
module four_step_fft_unit #(
    parameter int MAX_POINTS   = fsf_pkg::MAX_POINTS_DEF,
    parameter int TWIDDLE_BITS = fsf_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [15:0] sample_real, [31:16] sample_imag
    input  logic [fsf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] func
    input  logic [0:0]                         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [27:0] bin_real, [55:28] bin_imag, [67:56] bin_index, [71:68] zero
    output logic [fsf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // last_bin
    output logic                               o_m_axis_tlast,
    // [1:0] status
    output logic [1:0]                         o_m_axis_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fsf_pkg::PADDR_W-1:0]        paddr,
    input  logic [fsf_pkg::PDATA_W-1:0]        pwdata,
    output logic [fsf_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int LOG_MAX = $clog2(MAX_POINTS);
    localparam int HALF_W  = (LOG_MAX + 1) / 2;
    localparam int LG_W    = $clog2(LOG_MAX + 1);
    localparam int TW_FRAC = TWIDDLE_BITS - 1;
    localparam int W       = fsf_pkg::WORK_BITS;
    localparam int SB      = fsf_pkg::SAMPLE_BITS;
    localparam int IDX_W   = fsf_pkg::INDEX_BITS;
    localparam int P_W     = W + TWIDDLE_BITS;
    localparam int ACC_W   = P_W + 1 + HALF_W;
    localparam int RB_W    = ACC_W - TW_FRAC;
    localparam int PR_W    = P_W + 1 - TW_FRAC;
    localparam int SAT_W   = RB_W + 1;
    localparam int PAD_W   = fsf_pkg::OUT_TDATA_W - 2 * W - IDX_W;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [ACC_W-1:0] RND_ACC = ACC_W'(1) <<< (TW_FRAC - 1);
    localparam logic signed [P_W:0]     RND_P   = (P_W + 1)'(1) <<< (TW_FRAC - 1);

    typedef enum logic [7:0] {
        S_LOAD     = 8'b0000_0001,
        S_MAC      = 8'b0000_0010,
        S_DRAIN    = 8'b0000_0100,
        S_POST_MUL = 8'b0000_1000,
        S_POST_WR  = 8'b0001_0000,
        S_READY    = 8'b0010_0000,
        S_FETCH    = 8'b0100_0000,
        S_SPARE    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [3:0] r_size_log2;
    logic       r_inverse;
    logic       cfg_wr;

    // counters
    logic [LOG_MAX-1:0] r_load_count, n_load_count;
    logic [LOG_MAX-1:0] r_read_count, n_read_count;
    logic               r_stage_b, n_stage_b;
    logic [HALF_W-1:0]  r_o, n_o, r_p, n_p, r_i, n_i;
    logic [LOG_MAX-1:0] r_j, n_j, r_jp, n_jp;
    logic               r_v1, r_v2;

    // size decode
    logic [LG_W-1:0]    m_log, la, lb;
    logic [LOG_MAX-1:0] n_mask;
    logic [HALF_W-1:0]  mask_a, mask_b, lim_o, lim_p;
    logic [LOG_MAX-1:0] step_in, step_post, rd_addr, wr_addr;
    logic [LG_W-1:0]    sh_in;

    // handshake
    logic acc_in, is_pull, push_ok, drained, elem_done, out_load;

    // memories: work (samples / results) and mid (between passes)
    logic [2*W-1:0]     r_work [MAX_POINTS];
    logic [2*W-1:0]     r_mid  [MAX_POINTS];
    logic [2*W-1:0]     r_work_q, r_mid_q;
    logic               work_we, mid_we;
    logic [LOG_MAX-1:0] work_wa, work_ra;
    logic [2*W-1:0]     work_wd, mid_wd;

    // datapath
    logic signed [SB-1:0]           s_re, s_im;
    logic signed [SB:0]             push_im;
    logic signed [W-1:0]            push_re_w, push_im_w;
    logic signed [TWIDDLE_BITS-1:0] tw_c, tw_d;
    logic [LOG_MAX-1:0]             tw_j;
    logic signed [W-1:0]            op_r, op_i;
    logic signed [P_W-1:0]          r_prc, r_pid, r_prd, r_pic;
    logic signed [P_W:0]            mac_re, mac_im;
    logic signed [ACC_W-1:0]        r_acc_re, r_acc_im;
    logic signed [RB_W-1:0]         rb_re, rb_im;
    logic signed [SAT_W-1:0]        fb_re, fb_im;
    logic signed [W-1:0]            r_ar, r_ai;
    logic signed [PR_W-1:0]         pr_re, pr_im;

    // output register
    logic                    r_out_valid;
    logic signed [W-1:0]     r_out_re, r_out_im;
    logic [IDX_W-1:0]        r_out_idx;
    logic                    r_out_last;
    fsf_pkg::t_status        r_out_stat;

    function automatic logic signed [W-1:0] f_sat(input logic signed [SAT_W-1:0] v);
        logic signed [W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    // APB port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == fsf_pkg::REG_INVERSE)
                  ? {{(fsf_pkg::PDATA_W - 1){1'b0}}, r_inverse}
                  : {{(fsf_pkg::PDATA_W - 4){1'b0}}, r_size_log2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= fsf_pkg::SIZE_LOG2_RESET;
            r_inverse   <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == fsf_pkg::REG_INVERSE) begin
                r_inverse <= pwdata[0];
            end else begin
                r_size_log2 <= pwdata[3:0];
            end
        end
    end

    // size clamp and split N = N1*N2
    always_comb begin
        if (int'(r_size_log2) < fsf_pkg::MIN_LOG2) begin
            m_log = LG_W'(fsf_pkg::MIN_LOG2);
        end else if (int'(r_size_log2) > LOG_MAX) begin
            m_log = LG_W'(LOG_MAX);
        end else begin
            m_log = LG_W'(r_size_log2);
        end
    end

    assign la     = (m_log >> 1) + LG_W'(m_log[0]);
    assign lb     = m_log >> 1;
    assign n_mask = ~({LOG_MAX{1'b1}} << m_log);
    assign mask_a = ~({HALF_W{1'b1}} << la);
    assign mask_b = ~({HALF_W{1'b1}} << lb);
    assign lim_o  = r_stage_b ? mask_b : mask_a;
    assign lim_p  = r_stage_b ? mask_a : mask_b;

    // twiddle strides and addresses of both passes
    assign sh_in     = LG_W'(LOG_MAX) - (r_stage_b ? la : lb);
    assign step_in   = LOG_MAX'(r_p) << sh_in;
    assign step_post = LOG_MAX'(r_o) << (LG_W'(LOG_MAX) - m_log);
    assign rd_addr   = r_stage_b ? ((LOG_MAX'(r_o) << la) | LOG_MAX'(r_i))
                                 : ((LOG_MAX'(r_i) << la) | LOG_MAX'(r_o));
    assign wr_addr   = r_stage_b ? ((LOG_MAX'(r_p) << lb) | LOG_MAX'(r_o))
                                 : ((LOG_MAX'(r_p) << la) | LOG_MAX'(r_o));

    // input handshake
    assign o_s_axis_tready = (r_state == S_LOAD || r_state == S_READY)
                          && (!r_out_valid || i_m_axis_tready);
    assign acc_in    = i_s_axis_tvalid && o_s_axis_tready;
    assign is_pull   = (i_s_axis_tuser[0] == fsf_pkg::FUNC_PULL);
    assign push_ok   = acc_in && !is_pull && (r_state == S_LOAD);
    assign drained   = !r_v1 && !r_v2;
    assign elem_done = (r_state == S_DRAIN && drained && r_stage_b)
                    || (r_state == S_POST_WR);
    assign out_load  = (acc_in && is_pull && r_state == S_LOAD)
                    || (acc_in && !is_pull && r_state == S_READY)
                    || (r_state == S_FETCH);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_load_count = r_load_count;
        n_read_count = r_read_count;
        n_stage_b    = r_stage_b;
        n_o          = r_o;
        n_p          = r_p;
        n_i          = r_i;
        n_j          = r_j;
        n_jp         = r_jp;
        case (r_state)
            S_LOAD: begin
                if (push_ok) begin
                    if (r_load_count == n_mask) begin
                        n_state      = S_MAC;
                        n_load_count = '0;
                        n_stage_b    = 1'b0;
                        n_o          = '0;
                        n_p          = '0;
                        n_i          = '0;
                        n_j          = '0;
                        n_jp         = '0;
                    end else begin
                        n_load_count = r_load_count + 1'b1;
                    end
                end
            end
            S_MAC: begin
                n_i = r_i + 1'b1;
                n_j = r_j + step_in;
                if (r_i == lim_p) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (drained && !r_stage_b) begin
                    n_state = S_POST_MUL;
                end
            end
            S_POST_MUL: begin
                n_state = S_POST_WR;
            end
            S_READY: begin
                if (acc_in && is_pull) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_read_count == n_mask) begin
                    n_state      = S_LOAD;
                    n_read_count = '0;
                    n_load_count = '0;
                end else begin
                    n_state      = S_READY;
                    n_read_count = r_read_count + 1'b1;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // next output point of the pass
        if (elem_done) begin
            n_state = S_MAC;
            n_i     = '0;
            n_j     = '0;
            if (r_p == lim_p) begin
                n_p  = '0;
                n_jp = '0;
                if (r_o == lim_o) begin
                    n_o = '0;
                    if (r_stage_b) begin
                        n_state      = S_READY;
                        n_read_count = '0;
                    end else begin
                        n_stage_b = 1'b1;
                    end
                end else begin
                    n_o = r_o + 1'b1;
                end
            end else begin
                n_p  = r_p + 1'b1;
                n_jp = r_jp + step_post;
            end
        end

        // register write empties the unit
        if (cfg_wr) begin
            n_state      = S_LOAD;
            n_load_count = '0;
            n_read_count = '0;
            n_stage_b    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_load_count <= '0;
            r_read_count <= '0;
            r_stage_b    <= 1'b0;
            r_o          <= '0;
            r_p          <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_jp         <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_read_count <= n_read_count;
            r_stage_b    <= n_stage_b;
            r_o          <= n_o;
            r_p          <= n_p;
            r_i          <= n_i;
            r_j          <= n_j;
            r_jp         <= n_jp;
            r_v1         <= (r_state == S_MAC) && !cfg_wr;
            r_v2         <= r_v1 && !cfg_wr;
        end
    end

    // sample entry, conjugated in inverse mode
    assign s_re      = $signed(i_s_axis_tdata[SB-1:0]);
    assign s_im      = $signed(i_s_axis_tdata[2*SB-1:SB]);
    assign push_im   = r_inverse ? -((SB + 1)'(s_im)) : (SB + 1)'(s_im);
    assign push_re_w = W'(s_re);
    assign push_im_w = W'(push_im);

    // pass B result: round, conjugate in inverse mode, saturate
    assign rb_re = RB_W'((r_acc_re + RND_ACC) >>> TW_FRAC);
    assign rb_im = RB_W'((r_acc_im + RND_ACC) >>> TW_FRAC);
    assign fb_re = SAT_W'(rb_re);
    assign fb_im = r_inverse ? -(SAT_W'(rb_im)) : SAT_W'(rb_im);

    // pass A result after the inter-pass twiddle
    assign pr_re = PR_W'(((r_prc - r_pid) + RND_P) >>> TW_FRAC);
    assign pr_im = PR_W'(((r_prd + r_pic) + RND_P) >>> TW_FRAC);

    // work store: loads and pass B write, pass A and readout read
    // (each pass reads one store and writes the other, so no overlap)
    assign work_we = push_ok || (elem_done && r_stage_b);
    assign work_wa = push_ok ? r_load_count : wr_addr;
    assign work_wd = push_ok ? {push_im_w, push_re_w} : {f_sat(fb_im), f_sat(fb_re)};
    assign work_ra = (r_state == S_READY) ? r_read_count : rd_addr;

    always_ff @(posedge i_clk) begin
        if (work_we) begin
            r_work[work_wa] <= work_wd;
        end
        r_work_q <= r_work[work_ra];
    end

    assign mid_we = (r_state == S_POST_WR);
    assign mid_wd = {f_sat(SAT_W'(pr_im)), f_sat(SAT_W'(pr_re))};

    always_ff @(posedge i_clk) begin
        if (mid_we) begin
            r_mid[wr_addr] <= mid_wd;
        end
        r_mid_q <= r_mid[rd_addr];
    end

    // twiddle lookup
    assign tw_j = (r_state == S_DRAIN) ? r_jp : r_j;

    fsf_twiddle #(
        .MAX_POINTS   (MAX_POINTS),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_twiddle (
        .i_clk (i_clk),
        .i_j   (tw_j),
        .o_c   (tw_c),
        .o_d   (tw_d)
    );

    // complex multiply, shared by the sums and the inter-pass twiddle
    always_comb begin
        if (r_state == S_POST_MUL) begin
            op_r = r_ar;
            op_i = r_ai;
        end else if (r_stage_b) begin
            op_r = $signed(r_mid_q[W-1:0]);
            op_i = $signed(r_mid_q[2*W-1:W]);
        end else begin
            op_r = $signed(r_work_q[W-1:0]);
            op_i = $signed(r_work_q[2*W-1:W]);
        end
    end

    assign mac_re = r_prc - r_pid;
    assign mac_im = r_prd + r_pic;

    always_ff @(posedge i_clk) begin
        if (r_v1 || r_state == S_POST_MUL) begin
            r_prc <= op_r * tw_c;
            r_pid <= op_i * tw_d;
            r_prd <= op_r * tw_d;
            r_pic <= op_i * tw_c;
        end
        if (r_state == S_MAC && r_i == '0) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + mac_re;
            r_acc_im <= r_acc_im + mac_im;
        end
        if (r_state == S_DRAIN && drained) begin
            r_ar <= W'(rb_re);
            r_ai <= W'(rb_im);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == S_FETCH) begin
                r_out_re   <= $signed(r_work_q[W-1:0]);
                r_out_im   <= $signed(r_work_q[2*W-1:W]);
                r_out_idx  <= IDX_W'(r_read_count);
                r_out_last <= (r_read_count == n_mask);
                r_out_stat <= fsf_pkg::STAT_BIN;
            end else begin
                r_out_re   <= '0;
                r_out_im   <= '0;
                r_out_idx  <= '0;
                r_out_last <= 1'b0;
                r_out_stat <= (r_state == S_LOAD) ? fsf_pkg::STAT_EMPTY
                                                  : fsf_pkg::STAT_REJECT;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_idx, r_out_im, r_out_re};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_stat;

    // a new sum starts only once the previous one has left the pipeline
    a_mac_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC && r_i == '0) |-> (!r_v1 && !r_v2))
        else $error("sum restarted with products in flight");

    // a result never overwrites one the receiver has not taken
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_m_axis_tready))
        else $error("output register overwritten");

    // load and readout counters stay inside the transform length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_load_count | r_read_count) & ~n_mask) == '0)
        else $error("counter beyond transform length");

endmodule

// ----- tb/four_step_fft_unit_tb.sv -----
// Self-checking testbench of four_step_fft_unit: loads transforms, pulls bins, checks each bin.
// Depends on fsf_pkg and the RTL of four_step_fft_unit; holds its own fixed-point DFT predictor.
module four_step_fft_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS     = 4096;
    localparam int QTR      = NPTS / 4;
    localparam int FRAC     = 17;
    localparam int WD_LIMIT = 100000;
    localparam int SETTLE   = 20;

    typedef struct {
        logic [27:0]       re;
        logic [27:0]       im;
        logic [11:0]       idx;
        logic              last;
        fsf_pkg::t_status  st;
    } t_bin;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_valid;
    logic                            s_ready;
    logic [fsf_pkg::IN_TDATA_W-1:0]  s_data;
    logic [0:0]                      s_user;
    logic                            m_valid;
    logic                            m_ready;
    logic [fsf_pkg::OUT_TDATA_W-1:0] m_data;
    logic                            m_last;
    logic [1:0]                      m_user;
    logic                            psel, penable, pwrite;
    logic [fsf_pkg::PADDR_W-1:0]     paddr;
    logic [fsf_pkg::PDATA_W-1:0]     pwdata, prdata;
    logic                            pready;

    four_step_fft_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tlast(m_last), .o_m_axis_tuser(m_user),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    int          qcos [0:QTR];
    int          buf_re [NPTS];
    int          buf_im [NPTS];
    longint      mid_re [NPTS];
    longint      mid_im [NPTS];
    int          load_cnt, read_cnt;
    bit          bins_ready;
    int          cfg_size;
    bit          cfg_inv;
    t_bin        bin_q [$];
    int          errors;
    bit          idle_en;
    int          quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // quarter-wave cosine, Q30 Taylor series rounded to twiddle precision
    function automatic int cos_entry(int r);
        longint unsigned th60, th, x2, term, q;
        longint sum;
        th60 = (fsf_pkg::HALF_PI_Q60 / QTR) * 64'(r);
        th   = (th60 + (64'd1 << 29)) >> 30;
        x2   = (th * th) >> 30;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
        q = (unsigned'(sum) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
        if (q > (64'd1 << FRAC) - 1) q = (64'd1 << FRAC) - 1;
        return int'(q);
    endfunction

    // W_4096^j as c + i*d
    task automatic twiddle(input int j, output longint c, output longint d);
        int q, r;
        longint cv, sv, co, si;
        j  = j & (NPTS - 1);
        q  = j / QTR;
        r  = j % QTR;
        cv = qcos[r];
        sv = qcos[QTR - r];
        case (q)
            0: begin co = cv;  si = sv;  end
            1: begin co = -sv; si = cv;  end
            2: begin co = -cv; si = -sv; end
            default: begin co = sv; si = -cv; end
        endcase
        c = co;
        d = -si;
    endtask

    function automatic longint rnd17(longint v);
        return (v + (64'sd1 << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint sat28(longint v);
        if (v > 134217727) return 134217727;
        if (v < -134217728) return -134217728;
        return v;
    endfunction

    function automatic int eff_log2();
        if (cfg_size < fsf_pkg::MIN_LOG2) return fsf_pkg::MIN_LOG2;
        if (cfg_size > 12) return 12;
        return cfg_size;
    endfunction

    // four-step DFT over the loaded buffer, in place
    task automatic four_step_dft();
        int m, la, lb, n1c, n2c, sa, sb, sn;
        longint c, d, ar, ai, accr, acci, xr, xi;
        m   = eff_log2();
        la  = (m + 1) / 2;
        lb  = m / 2;
        n1c = 1 << la;
        n2c = 1 << lb;
        sa  = NPTS >> lb;
        sb  = NPTS >> la;
        sn  = NPTS >> m;
        for (int a = 0; a < n1c; a++) begin
            for (int b = 0; b < n2c; b++) begin
                accr = 0;
                acci = 0;
                for (int i = 0; i < n2c; i++) begin
                    twiddle(((i * b) & (n2c - 1)) * sa, c, d);
                    xr = buf_re[i * n1c + a];
                    xi = buf_im[i * n1c + a];
                    accr += xr * c - xi * d;
                    acci += xr * d + xi * c;
                end
                ar = rnd17(accr);
                ai = rnd17(acci);
                twiddle(a * b * sn, c, d);
                mid_re[b * n1c + a] = sat28(rnd17(ar * c - ai * d));
                mid_im[b * n1c + a] = sat28(rnd17(ar * d + ai * c));
            end
        end
        for (int b = 0; b < n2c; b++) begin
            for (int a = 0; a < n1c; a++) begin
                accr = 0;
                acci = 0;
                for (int i = 0; i < n1c; i++) begin
                    twiddle(((i * a) & (n1c - 1)) * sb, c, d);
                    xr = mid_re[b * n1c + i];
                    xi = mid_im[b * n1c + i];
                    accr += xr * c - xi * d;
                    acci += xr * d + xi * c;
                end
                ar = rnd17(accr);
                ai = rnd17(acci);
                if (cfg_inv) ai = -ai;
                buf_re[a * n2c + b] = int'(sat28(ar));
                buf_im[a * n2c + b] = int'(sat28(ai));
            end
        end
    endtask

    // advance the predictor by one accepted word
    task automatic predict_word(logic f, logic [15:0] re, logic [15:0] im);
        t_bin e;
        int   n, sr, si;
        n = 1 << eff_log2();
        e = '{re: '0, im: '0, idx: '0, last: 1'b0, st: fsf_pkg::STAT_BIN};
        if (f == fsf_pkg::FUNC_PUSH) begin
            if (bins_ready) begin
                e.st = fsf_pkg::STAT_REJECT;
                bin_q.push_back(e);
            end else begin
                sr = $signed(re);
                si = $signed(im);
                if (cfg_inv) si = -si;
                if (load_cnt < n) begin
                    buf_re[load_cnt] = sr;
                    buf_im[load_cnt] = si;
                    load_cnt++;
                end
                if (load_cnt >= n) begin
                    four_step_dft();
                    bins_ready = 1'b1;
                    read_cnt = 0;
                end
            end
        end else if (!bins_ready || read_cnt >= n) begin
            e.st = fsf_pkg::STAT_EMPTY;
            bin_q.push_back(e);
        end else begin
            e.re   = buf_re[read_cnt][27:0];
            e.im   = buf_im[read_cnt][27:0];
            e.idx  = read_cnt[11:0];
            e.last = (read_cnt == n - 1);
            bin_q.push_back(e);
            read_cnt++;
            if (read_cnt >= n) begin
                bins_ready = 1'b0;
                load_cnt = 0;
                read_cnt = 0;
            end
        end
    endtask

    // send one word; called right after a rising edge
    task automatic send_word(logic f, logic [15:0] re, logic [15:0] im);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= f;
        s_data  <= {im, re};
        do @(posedge i_clk); while (!s_ready);
        predict_word(f, re, im);
    endtask

    task automatic push_sample(logic [15:0] re, logic [15:0] im);
        send_word(fsf_pkg::FUNC_PUSH, re, im);
    endtask

    task automatic pull_bin();
        send_word(fsf_pkg::FUNC_PULL, 16'($urandom), 16'($urandom));
    endtask

    // drain outstanding bins, then let the unit settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (bin_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // APB write: setup then access; aborts any transform
    task automatic reg_write(logic idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == fsf_pkg::REG_SIZE_LOG2) cfg_size = val & 32'hF;
        else cfg_inv = val[0];
        load_cnt   = 0;
        read_cnt   = 0;
        bins_ready = 1'b0;
    endtask

    task automatic configure(int size, bit inv);
        wait_idle();
        reg_write(fsf_pkg::REG_SIZE_LOG2, 32'(size));
        reg_write(fsf_pkg::REG_INVERSE, 32'(inv));
    endtask

    task automatic run_transform(bit noise);
        int n;
        n = 1 << eff_log2();
        for (int k = 0; k < n; k++) begin
            if (noise && $urandom_range(0, 40) == 0) pull_bin();
            push_sample(16'($urandom), 16'($urandom));
        end
        if (noise && $urandom_range(0, 2) == 0) push_sample(16'($urandom), 16'($urandom));
        for (int k = 0; k < n; k++) pull_bin();
        if (noise && $urandom_range(0, 2) == 0) pull_bin();
    endtask

    // pulls before any load, abort of a partial load by a register write
    task automatic test_empty_and_abort();
        pull_bin();
        push_sample(16'h7FFF, 16'h8000);
        push_sample(16'h1234, 16'hFEDC);
        pull_bin();
        configure(0, 1'b0);
        pull_bin();
    endtask

    // smallest size: extreme samples, reject while pending, pull past the end
    task automatic test_extremes();
        logic [15:0] pat [4];
        pat = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        configure(6, 1'b1);
        for (int k = 0; k < 64; k++) push_sample(pat[k % 4], pat[(k / 4) % 4]);
        push_sample(16'h5555, 16'hAAAA);
        for (int k = 0; k < 64; k++) pull_bin();
        pull_bin();
        configure(7, 1'b0);
        for (int k = 0; k < 128; k++) push_sample(16'h7FFF, 16'h7FFF);
        for (int k = 0; k < 128; k++) pull_bin();
    endtask

    // random transforms at small sizes with stray pulls and pushes
    task automatic test_random();
        int words;
        words = 0;
        while (words < 1000) begin
            configure($urandom_range(0, 9) == 0 ? 8 : $urandom_range(0, 7),
                      $urandom_range(0, 1));
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 20)) push_sample(16'($urandom), 16'($urandom));
                wait_idle();
                reg_write(fsf_pkg::REG_INVERSE, 32'($urandom_range(0, 1)));
            end
            run_transform(1'b1);
            words += 2 << eff_log2();
        end
    endtask

    // size clamped from above (a short load stays incomplete), then a full
    // transform with no idling
    task automatic test_largest();
        configure(12, 1'b1);
        reg_write(fsf_pkg::REG_SIZE_LOG2, 32'd15);
        repeat (80) push_sample(16'($urandom), 16'($urandom));
        pull_bin();
        idle_en = 1'b0;
        configure(8, 1'b0);
        run_transform(1'b0);
    endtask

    // receiver with random stall bursts
    initial begin
        int stall;
        m_ready = 1'b1;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                m_ready <= (stall == 0);
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_bin e;
        if (i_rst_n && m_valid && m_ready) begin
            if (bin_q.size() == 0) begin
                $display("%0t: unexpected word tdata=%h tlast=%b tuser=%0d",
                         $realtime, m_data, m_last, m_user);
                errors++;
            end else begin
                e = bin_q.pop_front();
                if (m_data[27:0] !== e.re || m_data[55:28] !== e.im ||
                    m_data[67:56] !== e.idx || m_data[71:68] !== 4'd0 ||
                    m_last !== e.last || m_user !== e.st) begin
                    $display("%0t: mismatch exp re=%h im=%h idx=%0d last=%b st=%0d",
                             $realtime, e.re, e.im, e.idx, e.last, e.st);
                    $display("%0t:          got re=%h im=%h idx=%0d last=%b st=%0d",
                             $realtime, m_data[27:0], m_data[55:28], m_data[67:56],
                             m_last, m_user);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // main sequence
    initial begin
        s_valid      = 1'b0;
        s_data       = '0;
        s_user       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        quiet_cycles = 0;
        errors       = 0;
        idle_en      = 1'b1;
        load_cnt     = 0;
        read_cnt     = 0;
        bins_ready   = 1'b0;
        cfg_size     = fsf_pkg::SIZE_LOG2_RESET;
        cfg_inv      = 1'b0;
        for (int r = 0; r <= QTR; r++) qcos[r] = cos_entry(r);
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_abort();
        test_extremes();
        test_random();
        test_largest();

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
